[design/gbc_pkg.sv]
package gbc_pkg;

   // Field and state widths
   localparam int RAW_W      = 16;
   localparam int SCALED_W   = 13;
   localparam int CORR_W     = 14;
   localparam int FILT_W     = 22;
   localparam int MOTION_W   = 22;
   localparam int BSUM_W     = 21;
   localparam int COUNT_W    = 8;
   localparam int LIMIT_W    = 21;
   localparam int KEEP_W     = 9;
   localparam int STATUS_W   = 2;
   localparam int AXES       = 3;
   localparam int AXIS_W     = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_LIMIT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_KEEP_Q8 = 2'd2;

   // Register values after reset
   localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RESET = 8'd200;
   localparam logic [LIMIT_W-1:0] MOTION_LIMIT_RESET = 21'd500;
   localparam logic [KEEP_W-1:0]  FILTER_KEEP_RESET  = 9'd51;

   // Divide by ten: multiply by the rounded-up reciprocal and shift.
   // Exact for every magnitude of a 16 bit sample.
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd52429;

   // Filter weight of one whole (1.0 in Q8)
   localparam logic [KEEP_W-1:0] KEEP_ONE = 9'd256;

   // Window sum divider: magnitude of the bias sum over the sample count
   localparam int DIV_DVD_W = 20;
   localparam int DIV_DVS_W = COUNT_W;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_COLLECT = 2'd0,
      STATUS_REJECT  = 2'd1,
      STATUS_ACCEPT  = 2'd2,
      STATUS_RUN     = 2'd3
   } status_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic              load_raw;
      logic              scale;
      logic              accum;
      logic              clear_window;
      logic              div_start;
      logic              bias_write;
      logic [AXIS_W-1:0] div_axis;
      logic              clear_filter;
      logic              filt_mul;
      logic              filt_sum;
      logic              load_out;
      status_type        out_status;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic window_full;
      logic moved;
      logic div_done;
   } dp_stat_type;

endpackage

[design/gbc_div.sv]
module gbc_div #(
   parameter int DVD_W = gbc_pkg::DIV_DVD_W,
   parameter int DVS_W = gbc_pkg::DIV_DVS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_shift;
   logic             fits;

   // One restoring step per cycle: the dividend shifts out of the top of the
   // quotient register while the quotient bits shift in at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[DVD_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? DVS_W'(rem_shift - {1'b0, dvs_ff}) : rem_shift[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[design/gbc_datapath.sv]
module gbc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gbc_pkg::dp_cmd_type                  cmd,
   output gbc_pkg::dp_stat_type                 stat,
   input  logic signed [gbc_pkg::RAW_W-1:0]     gyro_raw_x,
   input  logic signed [gbc_pkg::RAW_W-1:0]     gyro_raw_y,
   input  logic signed [gbc_pkg::RAW_W-1:0]     gyro_raw_z,
   input  logic                                 csr_write_enable,
   input  logic [gbc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gbc_pkg::CSR_DATA_W-1:0]       csr_write_data,
   output logic [gbc_pkg::STATUS_W-1:0]         out_status,
   output logic signed [gbc_pkg::SCALED_W-1:0]  out_bias_x,
   output logic signed [gbc_pkg::SCALED_W-1:0]  out_bias_y,
   output logic signed [gbc_pkg::SCALED_W-1:0]  out_bias_z,
   output logic signed [gbc_pkg::CORR_W-1:0]    out_corrected_z,
   output logic signed [gbc_pkg::FILT_W-1:0]    out_filtered_z_q8
);

   import gbc_pkg::*;

   localparam int PROD_W   = RAW_W + RECIP_W;
   localparam int PKEEP_W  = KEEP_W + 1 + FILT_W;
   localparam int PNEW_W   = KEEP_W + 1 + CORR_W;
   localparam int ACC_W    = PKEEP_W + 1;

   // Configuration registers
   logic [COUNT_W-1:0] sample_count_ff;
   logic [LIMIT_W-1:0] motion_limit_ff;
   logic [KEEP_W-1:0]  filter_keep_ff;

   // Per-item lanes
   logic signed [RAW_W-1:0]    raw_ff    [AXES];
   logic signed [SCALED_W-1:0] scaled_ff [AXES];
   logic signed [SCALED_W-1:0] scaled_in [AXES];

   // Window state
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic signed [SCALED_W-1:0] prev_ff   [AXES];
   logic signed [SCALED_W-1:0] prev_in   [AXES];
   logic [MOTION_W-1:0]        motion_ff [AXES];
   logic [MOTION_W-1:0]        motion_in [AXES];
   logic signed [BSUM_W-1:0]   bsum_ff   [AXES];
   logic signed [BSUM_W-1:0]   bsum_in   [AXES];
   logic signed [SCALED_W-1:0] bias_ff   [AXES];

   // Filter state
   logic signed [CORR_W-1:0]   corr_ff, corr_in;
   logic signed [PKEEP_W-1:0]  pkeep_ff, pkeep_in;
   logic signed [PNEW_W-1:0]   pnew_ff, pnew_in;
   logic signed [FILT_W-1:0]   filt_ff;
   logic signed [ACC_W-1:0]    filt_acc;
   logic [KEEP_W-1:0]          keep_sat;
   logic signed [KEEP_W:0]     keep_old_s;
   logic signed [KEEP_W:0]     keep_new_s;

   // Divider hookup
   logic signed [BSUM_W-1:0]   div_sum;
   logic [BSUM_W-1:0]          div_mag;
   logic                       div_neg_ff;
   logic                       div_done;
   logic [DIV_DVD_W-1:0]       div_quo;
   logic signed [SCALED_W-1:0] div_bias;

   // Result registers
   logic [STATUS_W-1:0]        out_status_ff;
   logic signed [SCALED_W-1:0] out_bias_ff [AXES];
   logic signed [CORR_W-1:0]   out_corr_ff;
   logic signed [FILT_W-1:0]   out_filt_ff;

   logic [COUNT_W-1:0]         limit_n;
   logic                       moved;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= SAMPLE_COUNT_RESET;
         motion_limit_ff <= MOTION_LIMIT_RESET;
         filter_keep_ff  <= FILTER_KEEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_COUNT:   sample_count_ff <= csr_write_data[COUNT_W-1:0];
            CSR_MOTION_LIMIT:   motion_limit_ff <= csr_write_data[LIMIT_W-1:0];
            CSR_FILTER_KEEP_Q8: filter_keep_ff  <= csr_write_data[KEEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Scale each axis by one tenth, truncating toward zero, on the magnitude.
   always_comb begin
      logic [RAW_W-1:0]  mag;
      logic [PROD_W-1:0] prod;
      logic [SCALED_W-1:0] quo;
      for (int j = 0; j < AXES; j++) begin
         mag  = raw_ff[j][RAW_W-1] ? RAW_W'(-raw_ff[j]) : RAW_W'(raw_ff[j]);
         prod = PROD_W'(mag) * PROD_W'(RECIP_TEN);
         quo  = prod[RECIP_SHIFT +: SCALED_W];
         scaled_in[j] = raw_ff[j][RAW_W-1] ? SCALED_W'(-quo) : SCALED_W'(quo);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_raw) begin
         raw_ff[0] <= gyro_raw_x;
         raw_ff[1] <= gyro_raw_y;
         raw_ff[2] <= gyro_raw_z;
      end
      if (cmd.scale) begin
         for (int j = 0; j < AXES; j++) begin
            scaled_ff[j] <= scaled_in[j];
         end
      end
   end

   // Window accumulation: change magnitude, running sum, previous sample.
   // The first sample of a window has no predecessor and adds no change.
   always_comb begin
      logic signed [CORR_W-1:0] diff;
      logic [CORR_W-1:0]        diff_mag;
      count_in = count_ff + COUNT_W'(1);
      for (int j = 0; j < AXES; j++) begin
         diff = (count_ff == '0) ? '0
              : CORR_W'(scaled_ff[j]) - CORR_W'(prev_ff[j]);
         diff_mag     = diff[CORR_W-1] ? CORR_W'(-diff) : CORR_W'(diff);
         motion_in[j] = motion_ff[j] + MOTION_W'(diff_mag);
         bsum_in[j]   = bsum_ff[j] + BSUM_W'(scaled_ff[j]);
         prev_in[j]   = scaled_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_window) begin
         count_ff <= '0;
         for (int j = 0; j < AXES; j++) begin
            prev_ff[j]   <= '0;
            motion_ff[j] <= '0;
            bsum_ff[j]   <= '0;
         end
      end else if (cmd.accum) begin
         count_ff <= count_in;
         for (int j = 0; j < AXES; j++) begin
            prev_ff[j]   <= prev_in[j];
            motion_ff[j] <= motion_in[j];
            bsum_ff[j]   <= bsum_in[j];
         end
      end
   end

   // Window decision; a zero sample count acts as one.
   always_comb begin
      limit_n = (sample_count_ff == '0) ? COUNT_W'(1) : sample_count_ff;
      moved   = 1'b0;
      for (int j = 0; j < AXES; j++) begin
         if (motion_ff[j] > MOTION_W'(motion_limit_ff)) begin
            moved = 1'b1;
         end
      end
   end

   // Bias of one axis: magnitude of its sum over the window count, sign restored.
   assign div_sum  = bsum_ff[cmd.div_axis];
   assign div_mag  = div_sum[BSUM_W-1] ? BSUM_W'(-div_sum) : BSUM_W'(div_sum);
   assign div_bias = div_neg_ff ? SCALED_W'(-div_quo[SCALED_W-1:0])
                                : SCALED_W'(div_quo[SCALED_W-1:0]);

   gbc_div #(
      .DVD_W (DIV_DVD_W),
      .DVS_W (DIV_DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_mag[DIV_DVD_W-1:0]),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_neg_ff <= div_sum[BSUM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < AXES; j++) begin
            bias_ff[j] <= '0;
         end
      end else if (cmd.bias_write) begin
         bias_ff[cmd.div_axis] <= div_bias;
      end
   end

   // Filter, multiply step: correction and both weighted products.
   always_comb begin
      keep_sat   = (filter_keep_ff > KEEP_ONE) ? KEEP_ONE : filter_keep_ff;
      keep_old_s = signed'({1'b0, keep_sat});
      keep_new_s = signed'({1'b0, KEEP_W'(KEEP_ONE - keep_sat)});
      corr_in    = CORR_W'(scaled_ff[2]) - CORR_W'(bias_ff[2]);
      pkeep_in   = PKEEP_W'(keep_old_s) * PKEEP_W'(filt_ff);
      pnew_in    = PNEW_W'(keep_new_s) * PNEW_W'(corr_in);
   end

   // Filter, sum step: sum in Q16 and floor back to Q8.
   assign filt_acc = ACC_W'(pkeep_ff) + ACC_W'({pnew_ff, 8'b0});

   always_ff @(posedge clock) begin
      if (cmd.filt_mul) begin
         corr_ff  <= corr_in;
         pkeep_ff <= pkeep_in;
         pnew_ff  <= pnew_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_filter) begin
         filt_ff <= '0;
      end else if (cmd.filt_sum) begin
         filt_ff <= filt_acc[8 +: FILT_W];
      end
   end

   // Result registers, loaded once the previous item has been taken.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= cmd.out_status;
         for (int j = 0; j < AXES; j++) begin
            out_bias_ff[j] <= bias_ff[j];
         end
         out_corr_ff <= (cmd.out_status == STATUS_RUN) ? corr_ff : '0;
         out_filt_ff <= filt_ff;
      end
   end

   assign stat.window_full = count_ff >= limit_n;
   assign stat.moved       = moved;
   assign stat.div_done    = div_done;

   assign out_status        = out_status_ff;
   assign out_bias_x        = out_bias_ff[0];
   assign out_bias_y        = out_bias_ff[1];
   assign out_bias_z        = out_bias_ff[2];
   assign out_corrected_z   = out_corr_ff;
   assign out_filtered_z_q8 = out_filt_ff;

endmodule

[design/gbc_ctrl.sv]
module gbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gbc_pkg::dp_cmd_type   cmd,
   input  gbc_pkg::dp_stat_type  stat
);

   import gbc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ACCUM,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FILT_MUL,
      ST_FILT_SUM,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              calibrated_ff, calibrated_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;

   // Sequencing of one item and the commands for each step
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      calibrated_in = calibrated_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.div_axis  = axis_ff;
      cmd.out_status = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_raw = 1'b1;
               state_in     = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = calibrated_ff ? ST_FILT_MUL : ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            if (!stat.window_full) begin
               status_in = STATUS_COLLECT;
               state_in  = ST_DONE;
            end else if (stat.moved) begin
               cmd.clear_window = 1'b1;
               status_in        = STATUS_REJECT;
               state_in         = ST_DONE;
            end else begin
               axis_in  = '0;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.bias_write = 1'b1;
               if (axis_ff == AXIS_W'(AXES - 1)) begin
                  cmd.clear_filter = 1'b1;
                  calibrated_in    = 1'b1;
                  status_in        = STATUS_ACCEPT;
                  state_in         = ST_DONE;
               end else begin
                  axis_in  = axis_ff + AXIS_W'(1);
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_FILT_MUL: begin
            cmd.filt_mul = 1'b1;
            state_in     = ST_FILT_SUM;
         end
         ST_FILT_SUM: begin
            cmd.filt_sum = 1'b1;
            status_in    = STATUS_RUN;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // Hold the finished item until the result register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= '0;
         calibrated_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         status_ff     <= STATUS_COLLECT;
      end else begin
         state_ff      <= state_in;
         axis_ff       <= axis_in;
         calibrated_ff <= calibrated_in;
         rsp_valid_ff  <= rsp_valid_in;
         status_ff     <= status_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/gyro_bias_calibrate_filter_unit.sv]
// Channel  Handshake            Payload
// req      req_valid/req_ready  req_gyro_raw_x, req_gyro_raw_y, req_gyro_raw_z
// rsp      rsp_valid/rsp_ready  rsp_status, rsp_bias_x/y/z, rsp_corrected_z,
//                               rsp_filtered_z_q8
// csr      csr_write_enable     csr_index, csr_write_data (write only)
//
// While collecting or running, a result waits after its item is accepted for the
// scale, accumulate or filter steps of the sequencer; the next item is taken only
// once the result has been loaded into the result register.
// The item that closes an accepted window also waits for the shared divider, which
// produces one quotient bit per cycle for each of the three axes in turn.
// Reset is synchronous and active high; it restores register defaults and
// restarts calibration. A new item is taken while the last result still waits.
module gyro_bias_calibrate_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [gbc_pkg::RAW_W-1:0]     req_gyro_raw_x,
   input  logic signed [gbc_pkg::RAW_W-1:0]     req_gyro_raw_y,
   input  logic signed [gbc_pkg::RAW_W-1:0]     req_gyro_raw_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gbc_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [gbc_pkg::SCALED_W-1:0]  rsp_bias_x,
   output logic signed [gbc_pkg::SCALED_W-1:0]  rsp_bias_y,
   output logic signed [gbc_pkg::SCALED_W-1:0]  rsp_bias_z,
   output logic signed [gbc_pkg::CORR_W-1:0]    rsp_corrected_z,
   output logic signed [gbc_pkg::FILT_W-1:0]    rsp_filtered_z_q8,
   input  logic                                 csr_write_enable,
   input  logic [gbc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gbc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   import gbc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer
   gbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Arithmetic, window state and result registers
   gbc_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .gyro_raw_x        (req_gyro_raw_x),
      .gyro_raw_y        (req_gyro_raw_y),
      .gyro_raw_z        (req_gyro_raw_z),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .out_status        (rsp_status),
      .out_bias_x        (rsp_bias_x),
      .out_bias_y        (rsp_bias_y),
      .out_bias_z        (rsp_bias_z),
      .out_corrected_z   (rsp_corrected_z),
      .out_filtered_z_q8 (rsp_filtered_z_q8)
   );

`ifndef SYNTHESIS
   // One item at a time: the input closes right after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still open after an item was accepted");

   // Before calibration is reached the biases are still zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_COLLECT || rsp_status == STATUS_REJECT)
      |-> rsp_bias_x == '0 && rsp_bias_y == '0 && rsp_bias_z == '0)
      else $error("non-zero bias reported before calibration");

   // Correction and filter output are zero unless the block is running.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_RUN
      |-> rsp_corrected_z == '0 && rsp_filtered_z_q8 == '0)
      else $error("filter output present outside calibrated running");
`endif

endmodule
